// File: hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation core.
// Used by mexp_mulmod and modular_exponentiation_core; no dependencies.
package mexp_pkg;

    localparam int RES_W           = 30;
    localparam int BASE_W          = 63;
    localparam int EXP_W           = 63;
    localparam int EXPONENT_BITS_DEFAULT = 63;
    localparam int S_TDATA_W       = 128;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 32;

    localparam logic [RES_W-1:0] MODULUS_P   = 30'd1000000007;
    localparam logic [RES_W-1:0] INV_EXP     = 30'd1000000005;
    localparam logic [30:0]      BARRETT_MU  = 31'd1152921496;
    localparam logic [30:0]      RADIX       = 31'h4000_0000;
    localparam logic [RES_W-1:0] ONE         = 30'd1;

    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [30:0]      b;
        logic [RES_W-1:0] c;
    } mexp_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] r;
    } mexp_rsp_t;

    function automatic mexp_req_t mk_req(input logic [RES_W-1:0] a,
                                         input logic [30:0] b,
                                         input logic [RES_W-1:0] c);
        mexp_req_t req;
        req.start = 1'b1;
        req.a     = a;
        req.b     = b;
        req.c     = c;
        return req;
    endfunction

endpackage

// File: hdl/mexp_mulmod.sv
`timescale 1ns / 1ps
// Shared multiply-and-reduce unit: r = (a * b + c) mod P by Barrett reduction.
// One 32x32 multiplier is reused for the product, quotient estimate and q*P.
// Depends on mexp_pkg.
module mexp_mulmod (
    input  logic                aclk,
    input  logic                aresetn,
    input  mexp_pkg::mexp_req_t req,
    output mexp_pkg::mexp_rsp_t rsp
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_MU, U_QP, U_FIN} ustate_t;

    ustate_t          state_reg, state_next;
    logic [RES_W-1:0] a_reg, a_next;
    logic [30:0]      b_reg, b_next;
    logic [RES_W-1:0] c_reg, c_next;
    logic [59:0]      x_reg, x_next;
    logic [30:0]      q_reg, q_next;
    logic [31:0]      qp_reg, qp_next;
    mexp_rsp_t        rsp_reg, rsp_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] rem;
    logic [32:0] rem_p;
    logic [32:0] rem_2p;

    always_comb begin
        case (state_reg)
            U_MUL: begin
                mul_a = {2'b00, a_reg};
                mul_b = {1'b0, b_reg};
            end
            U_MU: begin
                mul_a = {1'b0, x_reg[59:29]};
                mul_b = {1'b0, BARRETT_MU};
            end
            U_QP: begin
                mul_a = {1'b0, q_reg};
                mul_b = {2'b00, MODULUS_P};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign rem    = x_reg[31:0] - qp_reg;
    assign rem_p  = {1'b0, rem} - {3'b000, MODULUS_P};
    assign rem_2p = {1'b0, rem} - {2'b00, MODULUS_P, 1'b0};

    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        x_next        = x_reg;
        q_next        = q_reg;
        qp_next       = qp_reg;
        rsp_next      = rsp_reg;
        rsp_next.done = 1'b0;
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    a_next     = req.a;
                    b_next     = req.b;
                    c_next     = req.c;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                x_next     = prod[59:0] + {30'd0, c_reg};
                state_next = U_MU;
            end
            U_MU: begin
                q_next     = prod[61:31];
                state_next = U_QP;
            end
            U_QP: begin
                qp_next    = prod[31:0];
                state_next = U_FIN;
            end
            U_FIN: begin
                if (!rem_2p[32]) begin
                    rsp_next.r = rem_2p[RES_W-1:0];
                end else if (!rem_p[32]) begin
                    rsp_next.r = rem_p[RES_W-1:0];
                end else begin
                    rsp_next.r = rem[RES_W-1:0];
                end
                rsp_next.done = 1'b1;
                state_next    = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= U_IDLE;
            rsp_reg.done <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rsp_reg.done <= rsp_next.done;
        end
        rsp_reg.r <= rsp_next.r;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        x_reg     <= x_next;
        q_reg     <= q_next;
        qp_reg    <= qp_next;
    end

    assign rsp = rsp_reg;

endmodule

// File: hdl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Modular exponentiation core, modulus P = 1000000007, right-to-left square-and-multiply.
// Depends on mexp_pkg and mexp_mulmod.
//
// One beat in gives one beat out. s_tuser selects power (0) or modular inverse (1, exponent
// P-2). All arithmetic runs on a single shared multiply-and-reduce unit: a request is
// registered, steps through the unit's states U_MUL, U_MU, U_QP and U_FIN, and its result
// comes back registered before the sequencer issues the next request, so the number of
// modular multiplies sets the latency. An item takes two multiplies that reduce the base
// first, one per set exponent bit and one square per exponent bit below the highest set one
// (the top bit needs no square); a zero exponent skips the multiplies and goes straight out.
// s_tready is high only between items; a finished result waits in the output register, so the
// next beat is taken while the result is still held. A new result only waits longer while the
// previous one is still held in the output register.
module modular_exponentiation_core #(
    parameter int EXPONENT_BITS = mexp_pkg::EXPONENT_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0]   s_tdata,  // base[62:0], exponent[125:63], zeros
    input  logic [mexp_pkg::S_TUSER_W-1:0]   s_tuser,  // op[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mexp_pkg::M_TDATA_W-1:0]   m_tdata   // result[29:0], zeros
);
    import mexp_pkg::*;

    localparam int EW = (EXPONENT_BITS > RES_W) ? EXPONENT_BITS : RES_W;

    typedef enum logic [2:0] {T_IDLE, T_RED_HI, T_RED_LO, T_STEP, T_ACC, T_SQR, T_OUT} tstate_t;

    tstate_t          state_reg, state_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [EW-1:0]    e_reg, e_next;
    logic [RES_W-1:0] acc_reg, acc_next;
    logic [RES_W-1:0] sq_reg, sq_next;
    mexp_req_t        req_reg, req_next;
    logic             m_valid_reg, m_valid_next;
    logic [RES_W-1:0] m_data_reg, m_data_next;

    mexp_rsp_t         rsp;
    logic [BASE_W-1:0] in_base;
    logic [EXP_W-1:0]  in_exp;
    logic              in_op;
    logic [EW-1:0]     e_in;
    logic              s_beat;

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign in_base  = s_tdata[BASE_W-1:0];
    assign in_exp   = s_tdata[BASE_W+EXP_W-1:BASE_W];
    assign in_op    = s_tuser[0];
    assign s_tready = (state_reg == T_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        e_in = '0;
        if (in_op == OP_INVERSE) begin
            e_in[RES_W-1:0] = INV_EXP;
        end else begin
            e_in[EXPONENT_BITS-1:0] = in_exp[EXPONENT_BITS-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        e_next        = e_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        req_next      = req_reg;
        req_next.start = 1'b0;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE: begin
                if (s_beat) begin
                    base_next = in_base;
                    e_next    = e_in;
                    acc_next  = ONE;
                    if (e_in == '0) begin
                        state_next = T_OUT;
                    end else begin
                        req_next   = mk_req({27'd0, in_base[62:60]}, RADIX, in_base[59:30]);
                        state_next = T_RED_HI;
                    end
                end
            end
            T_RED_HI: begin
                if (rsp.done) begin
                    req_next   = mk_req(rsp.r, RADIX, base_reg[29:0]);
                    state_next = T_RED_LO;
                end
            end
            T_RED_LO: begin
                if (rsp.done) begin
                    sq_next    = rsp.r;
                    state_next = T_STEP;
                end
            end
            T_STEP: begin
                if (e_reg == '0) begin
                    state_next = T_OUT;
                end else if (e_reg[0]) begin
                    req_next   = mk_req(acc_reg, {1'b0, sq_reg}, '0);
                    state_next = T_ACC;
                end else begin
                    req_next   = mk_req(sq_reg, {1'b0, sq_reg}, '0);
                    state_next = T_SQR;
                end
            end
            T_ACC: begin
                if (rsp.done) begin
                    acc_next = rsp.r;
                    if (e_reg[EW-1:1] == '0) begin
                        state_next = T_OUT;
                    end else begin
                        req_next   = mk_req(sq_reg, {1'b0, sq_reg}, '0);
                        state_next = T_SQR;
                    end
                end
            end
            T_SQR: begin
                if (rsp.done) begin
                    sq_next    = rsp.r;
                    e_next     = e_reg >> 1;
                    state_next = T_STEP;
                end
            end
            T_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            req_reg.start <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            req_reg.start <= req_next.start;
            m_valid_reg   <= m_valid_next;
        end
        req_reg.a  <= req_next.a;
        req_reg.b  <= req_next.b;
        req_reg.c  <= req_next.c;
        base_reg   <= base_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_data_reg};

endmodule
